// ===== hw/rtl/ssif_pkg.sv =====
package ssif_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int MAG_BITS   = CROSS_BITS - 1;
  localparam int REM_BITS   = MAG_BITS + 1;
  localparam int OUT_BITS   = FRAC_BITS + 1;

  typedef struct packed {
    logic                  valid;
    logic                  live;
    logic [REM_BITS-1:0]   rem;
    logic [MAG_BITS-1:0]   den;
    logic [FRAC_BITS-1:0]  quo;
    logic                  hit;
    logic [OUT_BITS-1:0]   frac;
  } div_lane_t;

endpackage

// ===== hw/rtl/segment_segment_intersect_fraction.sv =====
// Throughput: one transaction per cycle; busy is never asserted.
// Front end: differences, then 17x17 products, then cross differences, then sign
// and range tests; the divider is a row of FRAC_BITS restoring cells, one bit each.
// Synchronous active-high reset clears all valid flags; results are not
// back-pressured, the receiver must take every strobe.
module segment_segment_intersect_fraction (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] a_x,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] a_y,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] b_x,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] b_y,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] o_x,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] o_y,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] p_x,
  input  logic signed [ssif_pkg::COORD_BITS-1:0] p_y,
  output logic                              strobe,
  output logic                              hit,
  output logic [ssif_pkg::OUT_BITS-1:0]     fraction
);

  localparam int DB = ssif_pkg::DIFF_BITS;
  localparam int PB = ssif_pkg::PROD_BITS;
  localparam int CB = ssif_pkg::CROSS_BITS;
  localparam int MB = ssif_pkg::MAG_BITS;
  localparam int FB = ssif_pkg::FRAC_BITS;
  localparam int OB = ssif_pkg::OUT_BITS;

  // stage 1: differences
  logic                 s1_valid;
  logic signed [DB-1:0] abx, aby, apx, apy, aox, aoy, opx, opy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    abx <= DB'(b_x) - DB'(a_x);
    aby <= DB'(b_y) - DB'(a_y);
    apx <= DB'(p_x) - DB'(a_x);
    apy <= DB'(p_y) - DB'(a_y);
    aox <= DB'(o_x) - DB'(a_x);
    aoy <= DB'(o_y) - DB'(a_y);
    opx <= DB'(p_x) - DB'(o_x);
    opy <= DB'(p_y) - DB'(o_y);
  end

  // stage 2: products
  logic                 s2_valid;
  logic signed [PB-1:0] sp1, sp2, so1, so2, nu1, nu2, de1, de2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    sp1 <= abx * apy;
    sp2 <= aby * apx;
    so1 <= abx * aoy;
    so2 <= aby * aox;
    nu1 <= aox * opy;
    nu2 <= aoy * opx;
    de1 <= abx * opy;
    de2 <= aby * opx;
  end

  // stage 3: cross products
  logic                 s3_valid;
  logic signed [CB-1:0] sp, so, num, den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    sp  <= CB'(sp1) - CB'(sp2);
    so  <= CB'(so1) - CB'(so2);
    num <= CB'(nu1) - CB'(nu2);
    den <= CB'(de1) - CB'(de2);
  end

  // stage 4: normalize signs and classify, feed the divider row
  logic                 straddle;
  logic signed [CB-1:0] num_n, den_n;
  ssif_pkg::div_lane_t  head;

  always_comb begin
    straddle = (sp != '0) && (so != '0) && (sp[CB-1] != so[CB-1]);
    num_n    = den[CB-1] ? -num : num;
    den_n    = den[CB-1] ? -den : den;
    head       = '0;
    head.valid = s3_valid;
    head.rem   = {1'b0, num_n[MB-1:0]};
    head.den   = den_n[MB-1:0];
    head.frac  = OB'(1) << FB;
    if (straddle) begin
      if (num_n[CB-1]) begin
        head.frac = '0;
      end else if (num_n > den_n) begin
        head.frac = OB'(1) << FB;
      end else if (num_n == den_n) begin
        head.hit = 1'b1;
      end else begin
        head.hit  = 1'b1;
        head.live = 1'b1;
      end
    end
  end

  ssif_pkg::div_lane_t lanes [FB+1];
  ssif_pkg::div_lane_t head_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_q.valid <= 1'b0;
    end else begin
      head_q.valid <= head.valid;
    end
    head_q.live <= head.live;
    head_q.rem  <= head.rem;
    head_q.den  <= head.den;
    head_q.quo  <= head.quo;
    head_q.hit  <= head.hit;
    head_q.frac <= head.frac;
  end

  assign lanes[0] = head_q;

  for (genvar i = 0; i < FB; i++) begin : g_cell
    ssif_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (lanes[i]),
      .lane_out (lanes[i+1])
    );
  end

  assign busy     = 1'b0;
  assign strobe   = lanes[FB].valid;
  assign hit      = lanes[FB].hit;
  assign fraction = lanes[FB].live ? OB'(lanes[FB].quo) : lanes[FB].frac;

endmodule

// ===== hw/rtl/ssif_div_cell.sv =====
module ssif_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  ssif_pkg::div_lane_t lane_in,
  output ssif_pkg::div_lane_t lane_out
);

  logic [ssif_pkg::REM_BITS-1:0] shifted;
  logic [ssif_pkg::REM_BITS:0]   diff;
  ssif_pkg::div_lane_t           lane_next;

  always_comb begin
    shifted   = {lane_in.rem[ssif_pkg::REM_BITS-2:0], 1'b0};
    diff      = {1'b0, shifted} - {2'b00, lane_in.den};
    lane_next = lane_in;
    lane_next.quo = {lane_in.quo[ssif_pkg::FRAC_BITS-2:0], 1'b0};
    lane_next.rem = shifted;
    // restoring step: keep the difference when it did not borrow
    if (!diff[ssif_pkg::REM_BITS]) begin
      lane_next.rem    = diff[ssif_pkg::REM_BITS-1:0];
      lane_next.quo[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_in.valid;
    end
    lane_out.live <= lane_next.live;
    lane_out.rem  <= lane_next.rem;
    lane_out.den  <= lane_next.den;
    lane_out.quo  <= lane_next.quo;
    lane_out.hit  <= lane_next.hit;
    lane_out.frac <= lane_next.frac;
  end

endmodule
